[hw/rtl/mi3_pkg.sv]
package mi3_pkg;

  // Element format.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // Exact intermediate widths.
  localparam int PROD_BITS = 2 * WORD_BITS;         // element times element
  localparam int ADJ_BITS  = 2 * WORD_BITS + 1;     // difference of two products
  localparam int DET_BITS  = 3 * WORD_BITS + 3;     // sum of three element-cofactor products
  localparam int NUM_BITS  = ADJ_BITS + 2 * FRAC_BITS;
  localparam int SHD_BITS  = DET_BITS + WORD_BITS;
  localparam int REM_BITS  = (NUM_BITS > SHD_BITS) ? NUM_BITS : SHD_BITS;

  // Stream widths, padded to whole bytes.
  localparam int MAT_BITS   = 9 * WORD_BITS;
  localparam int TDATA_BITS = ((MAT_BITS + 7) / 8) * 8;

  // Pipeline depths.
  localparam int ADJ_STAGES  = 6;
  localparam int LANE_STAGES = WORD_BITS + 2;
  localparam int NUM_STAGES  = ADJ_STAGES + LANE_STAGES + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [ADJ_BITS-1:0]  adj_t;
  typedef logic signed [DET_BITS-1:0]  det_t;

  // Per-lane quotient and its range flags.
  typedef struct packed {
    logic [WORD_BITS-1:0] quo;
    logic                 neg;
    logic                 big;
  } lane_res_t;

endpackage

[hw/rtl/matrix3_inverse_unit.sv]
// 3x3 matrix inverse in signed Q16.16. Each input beat carries one matrix; the
// block forms the nine cofactors and the determinant exactly, then returns each
// inverse element as cofactor * 2^32 / determinant, truncated toward zero and
// saturated to the 32-bit range. A zero determinant sets the singular flag and
// returns all-zero elements. A new matrix is accepted every cycle unless a full
// pipeline is held by back-pressure; the depth from input beat to output beat is
// set mostly by the 32-step restoring division pipeline in each of the nine
// element lanes. Back-pressure stalls only the stages that hold data, so empty
// stages keep filling while a result waits.
module matrix3_inverse_unit
  import mi3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input matrix: a00, a01, a02, a10, a11, a12, a20, a21, a22 from the lowest bit up.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_BITS-1:0] s_tdata,
  // Inverse: inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22 from the lowest bit up.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata,
  // Flag: singular.
  output logic                  m_tuser
);

  // Stage valids and load enables. A stage loads when it is empty or its
  // successor is loading, so bubbles collapse under back-pressure.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  assign en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
  for (genvar i = 0; i < NUM_STAGES - 1; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[NUM_STAGES-1];

  // Cofactors and determinant.
  word_t a_in [9];
  adj_t  adj  [9];
  det_t  det;

  always_comb begin
    for (int k = 0; k < 9; k++) a_in[k] = s_tdata[k*WORD_BITS +: WORD_BITS];
  end

  mi3_adj u_adj (
    .clk (clk),
    .en  (en[ADJ_STAGES-1:0]),
    .a   (a_in),
    .adj (adj),
    .det (det)
  );

  // Nine division lanes work side by side, one per inverse element.
  lane_res_t lres [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_lane u_lane (
      .clk (clk),
      .en  (en[ADJ_STAGES +: LANE_STAGES]),
      .adj (adj[k]),
      .det (det),
      .res (lres[k])
    );
  end

  // The zero-determinant flag travels beside the lanes.
  logic zero_pipe [LANE_STAGES];

  always_ff @(posedge clk) begin
    if (en[ADJ_STAGES]) zero_pipe[0] <= (det == '0);
    for (int i = 1; i < LANE_STAGES; i++) begin
      if (en[ADJ_STAGES+i]) zero_pipe[i] <= zero_pipe[i-1];
    end
  end

  // Merge stage: sign, saturation and the singular case, into the output register.
  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic [WORD_BITS-1:0] inv_next [9];
  logic [WORD_BITS-1:0] inv      [9];
  logic                 singular;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (zero_pipe[LANE_STAGES-1]) begin
        inv_next[k] = '0;
      end else if (!lres[k].neg) begin
        inv_next[k] = (lres[k].big || lres[k].quo[WORD_BITS-1]) ? WORD_MAX : lres[k].quo;
      end else if (lres[k].big || (lres[k].quo[WORD_BITS-1] && |lres[k].quo[WORD_BITS-2:0])) begin
        inv_next[k] = WORD_MIN;
      end else begin
        inv_next[k] = -lres[k].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      inv      <= inv_next;
      singular <= zero_pipe[LANE_STAGES-1];
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < 9; k++) m_tdata[k*WORD_BITS +: WORD_BITS] = inv[k];
  end
  assign m_tuser = singular;

`ifndef SYNTHESIS
  // A singular result carries only zero elements.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("singular result with nonzero elements");

  // With the output register empty, the whole pipeline can advance.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  // An accepted beat always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted beat lost at the first stage");
`endif

endmodule

[hw/rtl/mi3_adj.sv]
module mi3_adj
  import mi3_pkg::*;
(
  input  logic                  clk,
  input  logic [ADJ_STAGES-1:0] en,
  input  word_t                 a [9],
  output adj_t                  adj [9],
  output det_t                  det
);

  // Cofactor k is a[PL]*a[PR] - a[ML]*a[MR].
  localparam int PL [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PR [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int ML [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int MR [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic signed [PROD_BITS-1:0] pp [9];
  logic signed [PROD_BITS-1:0] pm [9];
  word_t                       row1 [3];
  word_t                       row2 [3];
  adj_t                        adj2 [9];
  adj_t                        adj3 [9];
  adj_t                        adj4 [9];
  adj_t                        adj5 [9];
  logic signed [WORD_BITS:0]   opnd_lo [3];
  logic signed [WORD_BITS:0]   opnd_hi [3];
  logic signed [2*WORD_BITS:0] plo [3];
  logic signed [2*WORD_BITS:0] phi [3];
  det_t                        term [3];
  det_t                        sum01;
  det_t                        term2;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      opnd_lo[j] = {1'b0, adj2[3*j][WORD_BITS-1:0]};
      opnd_hi[j] = adj2[3*j][ADJ_BITS-1:WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 9; k++) begin
        pp[k] <= a[PL[k]] * a[PR[k]];
        pm[k] <= a[ML[k]] * a[MR[k]];
      end
      for (int j = 0; j < 3; j++) row1[j] <= a[j];
    end
    if (en[1]) begin
      for (int k = 0; k < 9; k++) begin
        adj2[k] <= {pp[k][PROD_BITS-1], pp[k]} - {pm[k][PROD_BITS-1], pm[k]};
      end
      row2 <= row1;
    end
    // The determinant products are split so that no multiplier exceeds one word plus a bit.
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        plo[j] <= row2[j] * opnd_lo[j];
        phi[j] <= row2[j] * opnd_hi[j];
      end
      adj3 <= adj2;
    end
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        term[j] <= (DET_BITS'(phi[j]) <<< WORD_BITS) + DET_BITS'(plo[j]);
      end
      adj4 <= adj3;
    end
    if (en[4]) begin
      sum01 <= term[0] + term[1];
      term2 <= term[2];
      adj5  <= adj4;
    end
    if (en[5]) begin
      det <= sum01 + term2;
      adj <= adj5;
    end
  end

endmodule

[hw/rtl/mi3_lane.sv]
module mi3_lane
  import mi3_pkg::*;
(
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  adj_t                   adj,
  input  det_t                   det,
  output lane_res_t              res
);

  logic [ADJ_BITS-1:0]  adj_mag;
  logic [DET_BITS-1:0]  det_mag;
  logic [NUM_BITS-1:0]  nmag;
  logic [DET_BITS-1:0]  dmag;
  logic                 neg0;
  logic [REM_BITS-1:0]  rem [WORD_BITS+1];
  logic [DET_BITS-1:0]  dq  [WORD_BITS+1];
  logic [WORD_BITS-1:0] q   [WORD_BITS+1];
  logic                 ng  [WORD_BITS+1];
  logic                 bg  [WORD_BITS+1];

  assign adj_mag = adj[ADJ_BITS-1] ? ADJ_BITS'(-adj) : ADJ_BITS'(adj);
  assign det_mag = det[DET_BITS-1] ? DET_BITS'(-det) : DET_BITS'(det);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nmag <= {adj_mag, {(2*FRAC_BITS){1'b0}}};
      dmag <= det_mag;
      neg0 <= adj[ADJ_BITS-1] ^ det[DET_BITS-1];
    end
    // A quotient of a full word or more saturates either way.
    if (en[1]) begin
      rem[0] <= REM_BITS'(nmag);
      dq[0]  <= dmag;
      q[0]   <= '0;
      ng[0]  <= neg0;
      bg[0]  <= REM_BITS'(nmag) >= (REM_BITS'(dmag) << WORD_BITS);
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
    localparam int SH = WORD_BITS - 1 - k;
    logic [REM_BITS-1:0] trial;
    assign trial = REM_BITS'(dq[k]) << SH;
    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          q[k+1]   <= {q[k][WORD_BITS-2:0], 1'b1};
        end else begin
          rem[k+1] <= rem[k];
          q[k+1]   <= {q[k][WORD_BITS-2:0], 1'b0};
        end
        dq[k+1] <= dq[k];
        ng[k+1] <= ng[k];
        bg[k+1] <= bg[k];
      end
    end
  end

  assign res.quo = q[WORD_BITS];
  assign res.neg = ng[WORD_BITS];
  assign res.big = bg[WORD_BITS];

  logic unused_tail;
  assign unused_tail = ^{rem[WORD_BITS], dq[WORD_BITS]};

endmodule
